// ----- rtl/kwd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwd_pkg
// Types, codes and constants shared by the keyed watchdog modules.
// ----------------------------------------------------------------------------
package kwd_pkg;

    localparam int DATA_WIDTH          = 32;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam logic [DATA_WIDTH-1:0] UNLOCK_KEY = 32'hf1d0_dead;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_CLEAR = 2'd3
    } kwd_cmd_t;

    typedef enum logic [1:0] {
        REG_COUNT     = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_ENABLE    = 2'd2,
        REG_SAFE      = 2'd3
    } kwd_reg_t;

    localparam int CLR_PRETIMEOUT_BIT = 0;
    localparam int CLR_TIMEOUT_BIT    = 1;

    typedef struct packed {
        kwd_cmd_t              command;
        kwd_reg_t              reg_index;
        logic [DATA_WIDTH-1:0] write_data;
        logic [1:0]            clear_mask;
    } kwd_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  write_done;
        logic                  pretimeout_irq;
        logic                  timeout_irq;
    } kwd_result_t;

endpackage
`default_nettype wire

// ----- rtl/kwd_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwd_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module kwd_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire kwd_pkg::kwd_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kwd_pkg::kwd_item_t     out_item
);
    import kwd_pkg::*;

    logic      valid_reg;
    kwd_item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kwd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwd_core
// Watchdog registers, key lock and sticky flags. Computes the result of
// one item and commits the state update when the item is consumed.
// ----------------------------------------------------------------------------
module kwd_core #(
    parameter int COUNT_WIDTH = kwd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_fire,
    input  wire kwd_pkg::kwd_item_t item,
    output kwd_pkg::kwd_result_t    result
);
    import kwd_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] threshold_reg, threshold_next;
    logic                   running_reg, running_next;
    logic                   unlocked_reg, unlocked_next;
    logic                   pre_flag_reg, pre_flag_next;
    logic                   to_flag_reg, to_flag_next;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic [COUNT_WIDTH-1:0] data_trunc;
    logic [DATA_WIDTH-1:0]  read_data;
    logic                   write_done;

    assign count_dec  = count_reg - COUNT_WIDTH'(1);
    assign data_trunc = COUNT_WIDTH'(item.write_data);

    always_comb begin
        count_next     = count_reg;
        threshold_next = threshold_reg;
        running_next   = running_reg;
        unlocked_next  = unlocked_reg;
        pre_flag_next  = pre_flag_reg;
        to_flag_next   = to_flag_reg;
        read_data      = '0;
        write_done     = 1'b0;
        unique case (item.command)
            CMD_TICK: begin
                if (running_reg && (count_reg != '0)) begin
                    count_next = count_dec;
                    if ((threshold_reg != '0) && (count_dec == threshold_reg)) begin
                        pre_flag_next = 1'b1;
                    end
                    if (count_dec == '0) begin
                        to_flag_next = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                unique case (item.reg_index)
                    REG_COUNT:     read_data = DATA_WIDTH'(count_reg);
                    REG_THRESHOLD: read_data = DATA_WIDTH'(threshold_reg);
                    REG_ENABLE:    read_data = DATA_WIDTH'(running_reg);
                    REG_SAFE:      read_data = '0;
                    default:       read_data = '0;
                endcase
            end
            CMD_WRITE: begin
                if (item.reg_index == REG_SAFE) begin
                    unlocked_next = (item.write_data == UNLOCK_KEY);
                    write_done    = (item.write_data == UNLOCK_KEY);
                end else if (unlocked_reg) begin
                    unlocked_next = 1'b0;
                    write_done    = 1'b1;
                    unique case (item.reg_index)
                        REG_COUNT:     count_next     = data_trunc;
                        REG_THRESHOLD: threshold_next = data_trunc;
                        default:       running_next   = item.write_data[0];
                    endcase
                end
            end
            CMD_CLEAR: begin
                if (item.clear_mask[CLR_PRETIMEOUT_BIT]) begin
                    pre_flag_next = 1'b0;
                end
                if (item.clear_mask[CLR_TIMEOUT_BIT]) begin
                    to_flag_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign result.read_data      = read_data;
    assign result.write_done     = write_done;
    assign result.pretimeout_irq = pre_flag_next;
    assign result.timeout_irq    = to_flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '1;
            threshold_reg <= '0;
            running_reg   <= 1'b0;
            unlocked_reg  <= 1'b0;
            pre_flag_reg  <= 1'b0;
            to_flag_reg   <= 1'b0;
        end else if (item_fire) begin
            count_reg     <= count_next;
            threshold_reg <= threshold_next;
            running_reg   <= running_next;
            unlocked_reg  <= unlocked_next;
            pre_flag_reg  <= pre_flag_next;
            to_flag_reg   <= to_flag_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kwd_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwd_out_stage
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module kwd_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire kwd_pkg::kwd_result_t in_result,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kwd_pkg::kwd_result_t      out_result
);
    import kwd_pkg::*;

    logic        valid_reg;
    kwd_result_t result_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/keyed_watchdog_with_threshold_irq_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_watchdog_with_threshold_irq_core
// Keyed watchdog timer with a pre-timeout interrupt flag.
// Path from input transfer to result valid: the input register, then the result
// register; the state update and result are combinational logic between them.
// Throughput: one item per cycle, limited only by the result handshake.
// Reset: synchronous, active low; count all ones, threshold zero, disabled,
// locked, both flags clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
module keyed_watchdog_with_threshold_irq_core #(
    parameter int COUNT_WIDTH = kwd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [1:0]  s_reg_index,
    input  wire logic [31:0] s_write_data,
    input  wire logic [1:0]  s_clear_mask,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_data,
    output logic             m_write_done,
    output logic             m_pretimeout_irq,
    output logic             m_timeout_irq
);
    import kwd_pkg::*;

    kwd_item_t   s_item;
    kwd_item_t   core_item;
    kwd_result_t core_result;
    kwd_result_t m_result;
    logic        core_valid;
    logic        core_ready;

    assign s_item.command    = kwd_cmd_t'(s_command);
    assign s_item.reg_index  = kwd_reg_t'(s_reg_index);
    assign s_item.write_data = s_write_data;
    assign s_item.clear_mask = s_clear_mask;

    kwd_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    kwd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (core_valid && core_ready),
        .item      (core_item),
        .result    (core_result)
    );

    kwd_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (core_valid),
        .in_ready   (core_ready),
        .in_result  (core_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

    assign m_read_data      = m_result.read_data;
    assign m_write_done     = m_result.write_done;
    assign m_pretimeout_irq = m_result.pretimeout_irq;
    assign m_timeout_irq    = m_result.timeout_irq;

endmodule
`default_nettype wire
